/* src/lvc_pkg.sv */
// Package for the verdict cache: item kind codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package lvc_pkg;

    // Item kind codes as carried in the kind field.
    localparam logic [1:0] KIND_SEARCH = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted item
        logic start;   // begin a read sweep over all entries
        logic scan;    // sweep data goes to the match/victim search
        logic update;  // sweep data is rewritten with new ranks
        logic clear;   // write reset contents, one entry a cycle
        logic emit;    // load the result register and counters
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       done;      // last entry of the current sweep handled
        logic       found;     // search matched an entry
        logic       out_free;  // result register can take a new item
        logic [1:0] req_kind;  // kind of the item at the input
        logic [1:0] op_kind;   // kind of the item in progress
    } status_t;

endpackage

/* src/lvc_if.sv */
// Valid/ready channel interfaces for request and result items.
// Depends on nothing.
interface lvc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] key;
    logic [3:0]  verdict_in;

    modport source (output valid, kind, key, verdict_in, input ready);
    modport sink   (input valid, kind, key, verdict_in, output ready);
endinterface

interface lvc_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [3:0]  verdict_out;
    logic [63:0] hit_total;
    logic [63:0] miss_total;

    modport source (output valid, hit, verdict_out, hit_total, miss_total, input ready);
    modport sink   (input valid, hit, verdict_out, hit_total, miss_total, output ready);
endinterface

/* src/lvc_ctrl.sv */
// Controller state machine of the verdict cache: sequences the sweeps.
// Depends on lvc_pkg.
module lvc_ctrl
    import lvc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register; reset starts with a clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    case (status.req_kind)
                        KIND_SEARCH, KIND_INSERT:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_SCAN;
                        end
                        KIND_FLUSH:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.done)
                begin
                    if (status.op_kind == KIND_INSERT || status.found)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (status.done)
                begin
                    state_next = (status.op_kind == KIND_SEARCH) ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/lvc_datapath.sv */
// Datapath of the verdict cache: entry memory, sweep counter, match and
// rank logic, counters and result register. Depends on lvc_pkg.
module lvc_datapath
    import lvc_pkg::*;
#(
    parameter int ENTRIES      = 256,
    parameter int VERDICT_BITS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [1:0]  kind,
    input  logic [31:0] key,
    input  logic [3:0]  verdict_in,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        hit,
    output logic [3:0]  verdict_out,
    output logic [63:0] hit_total,
    output logic [63:0] miss_total
);

    localparam int IW      = $clog2(ENTRIES);
    localparam int VB      = VERDICT_BITS;
    localparam int W       = 32 + VB + 2 * IW;
    localparam int IR_LSB  = 0;
    localparam int RR_LSB  = IW;
    localparam int VER_LSB = 2 * IW;
    localparam int KEY_LSB = VB + 2 * IW;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    logic [W-1:0]    mem [ENTRIES];
    logic [IW-1:0]   idx_reg;
    logic            issue_reg;
    logic            rd_valid_reg;
    logic [IW-1:0]   rd_idx_reg;
    logic [W-1:0]    rd_word_reg;
    logic [1:0]      op_kind_reg;
    logic [31:0]     key_reg;
    logic [VB-1:0]   vin_reg;
    logic            found_reg;
    logic [IW-1:0]   best_reg;
    logic [IW-1:0]   best_irank_reg;
    logic [IW-1:0]   old_rank_reg;
    logic [VB-1:0]   best_verdict_reg;
    logic [63:0]     hit_cnt_reg;
    logic [63:0]     miss_cnt_reg;
    logic            out_valid_reg;
    logic            out_hit_reg;
    logic [3:0]      out_verdict_reg;

    logic [31:0]     w_key;
    logic [VB-1:0]   w_ver;
    logic [IW-1:0]   w_rr;
    logic [IW-1:0]   w_ir;
    logic            match;
    logic            is_victim;
    logic            we;
    logic [IW-1:0]   wa;
    logic [W-1:0]    wd;
    logic [IW-1:0]   new_rr;
    logic [IW-1:0]   new_ir;
    logic [15:0]     vin_wide;
    logic [15:0]     ver_wide;

    // Fields of the word read in the previous cycle.
    assign w_key = rd_word_reg[KEY_LSB +: 32];
    assign w_ver = rd_word_reg[VER_LSB +: VB];
    assign w_rr  = rd_word_reg[RR_LSB +: IW];
    assign w_ir  = rd_word_reg[IR_LSB +: IW];

    // A match that beats the best so far goes to the earliest inserted entry.
    assign match = (key_reg != 32'd0) && (w_key == key_reg)
                 && (!found_reg || (w_ir > best_irank_reg));
    assign is_victim = (w_rr == LAST);

    assign vin_wide = {12'd0, verdict_in};
    assign ver_wide = 16'(best_verdict_reg);

    // Sweep address counter: one entry a cycle, wraps back to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue_reg;
            if (cmd.start)
            begin
                idx_reg   <= '0;
                issue_reg <= 1'b1;
            end
            else if (issue_reg || cmd.clear)
            begin
                idx_reg   <= (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                issue_reg <= issue_reg && (idx_reg != LAST);
            end
        end
    end

    // Rank adjustment and write data for update and clearing sweeps.
    always_comb
    begin
        new_rr = (w_rr < old_rank_reg) ? w_rr + 1'b1 : w_rr;
        new_ir = (op_kind_reg == KIND_INSERT && w_ir < best_irank_reg) ? w_ir + 1'b1 : w_ir;
        wd     = rd_word_reg;
        if (rd_idx_reg == best_reg)
        begin
            new_rr = '0;
            if (op_kind_reg == KIND_INSERT)
            begin
                new_ir = '0;
                wd[KEY_LSB +: 32] = key_reg;
                wd[VER_LSB +: VB] = vin_reg;
            end
        end
        wd[RR_LSB +: IW] = new_rr;
        wd[IR_LSB +: IW] = new_ir;
        we = cmd.update && rd_valid_reg;
        wa = rd_idx_reg;
        if (cmd.clear)
        begin
            we = 1'b1;
            wa = idx_reg;
            wd = {32'd0, {VB{1'b0}}, idx_reg, idx_reg};
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_word_reg <= mem[idx_reg];
        rd_idx_reg  <= idx_reg;
    end

    // Item capture and search results of the scan sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan && rd_valid_reg && op_kind_reg == KIND_SEARCH && match)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_kind_reg <= kind;
            key_reg     <= key;
            vin_reg     <= vin_wide[VB-1:0];
        end
        if (cmd.scan && rd_valid_reg)
        begin
            if ((op_kind_reg == KIND_SEARCH && match)
                || (op_kind_reg == KIND_INSERT && is_victim))
            begin
                best_reg         <= rd_idx_reg;
                best_irank_reg   <= w_ir;
                old_rank_reg     <= w_rr;
                best_verdict_reg <= w_ver;
            end
        end
    end

    // Counters and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
            if (found_reg)
            begin
                hit_cnt_reg <= hit_cnt_reg + 64'd1;
            end
            else
            begin
                miss_cnt_reg <= miss_cnt_reg + 64'd1;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_hit_reg     <= found_reg;
            out_verdict_reg <= found_reg ? ver_wide[3:0] : 4'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign verdict_out = out_verdict_reg;
    assign hit_total   = hit_cnt_reg;
    assign miss_total  = miss_cnt_reg;

    // Status back to the controller.
    always_comb
    begin
        status.done     = cmd.clear ? (idx_reg == LAST)
                                    : (rd_valid_reg && rd_idx_reg == LAST);
        status.found    = found_reg || (rd_valid_reg && match);
        status.out_free = !out_valid_reg || out_ready;
        status.req_kind = kind;
        status.op_kind  = op_kind_reg;
    end

endmodule

/* src/lru_verdict_cache_unit.sv */
// Top level of the verdict cache: joins controller and datapath.
// Depends on lvc_pkg, lvc_if, lvc_ctrl and lvc_datapath.
//
// Fully associative LRU cache mapping nonzero 32-bit keys to verdicts.
// The req channel takes items of kind search, insert or flush; the rsp
// channel gives one result item per search (hit, verdict, hit and miss
// totals after that search). Insert, flush and unknown kinds give none.
// Search and insert items sweep the entry memory one entry a cycle through
// its single read port and registered read data; a search hit and an insert
// add an update sweep that rewrites the ranks. A flush rewrites every entry.
// One item is worked on at a time; req.ready is high only while idle.
// After reset a clearing pass writes every entry before the first item is
// taken. A finished result waits in the output register while the next item
// is accepted; a further search result waits for it to be taken before
// completing.
module lru_verdict_cache_unit
    import lvc_pkg::*;
#(
    parameter int ENTRIES      = 256,
    parameter int VERDICT_BITS = 4
)
(
    input logic       clk,
    input logic       rst_n,
    lvc_req_if.sink   req,
    lvc_rsp_if.source rsp
);

    cmd_t    cmd;
    status_t status;

    lvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lvc_datapath #(
        .ENTRIES      (ENTRIES),
        .VERDICT_BITS (VERDICT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (req.kind),
        .key         (req.key),
        .verdict_in  (req.verdict_in),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .hit         (rsp.hit),
        .verdict_out (rsp.verdict_out),
        .hit_total   (rsp.hit_total),
        .miss_total  (rsp.miss_total)
    );

endmodule

/* src/lvc_checker.sv */
// Port-level checks on the verdict cache, bound to the top level.
// Depends on lru_verdict_cache_unit.
module lvc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        hit,
    input logic [3:0]  verdict_out,
    input logic [63:0] hit_total,
    input logic [63:0] miss_total
);

    // A stalled result stays valid and holds its hit and miss totals.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit_total) && $stable(miss_total))
        else $error("stalled result changed");

    // A miss reports a zero verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> verdict_out == 4'd0)
        else $error("miss with nonzero verdict");

    // A hit result has counted at least that hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && hit |-> hit_total != 64'd0)
        else $error("hit not counted");

    // A miss result has counted at least that miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> miss_total != 64'd0)
        else $error("miss not counted");

endmodule

bind lru_verdict_cache_unit lvc_checker u_lvc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .hit         (rsp.hit),
    .verdict_out (rsp.verdict_out),
    .hit_total   (rsp.hit_total),
    .miss_total  (rsp.miss_total)
);

/* tb/tb_lru_verdict_cache_unit.sv */
// Self-checking testbench for lru_verdict_cache_unit: directed table, then random items.
// Depends on lvc_pkg, lvc_if and the RTL of the cache; it has its own model of the cache.
module tb_lru_verdict_cache_unit
    import lvc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 256;
    localparam int RAND_ITEMS = 700;
    localparam int POOL_SIZE  = 320;
    localparam int HOLD_LEN   = 3000;
    localparam int TAIL_WAIT  = 2 * DEPTH + 40;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic        hit;
        logic [3:0]  verdict;
        logic [63:0] hits;
        logic [63:0] misses;
    } lookup_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [3:0]  verdict;
        bit          typed;
        lookup_t     want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lvc_req_if req ();
    lvc_rsp_if rsp ();

    lru_verdict_cache_unit dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    // Model of the cache contents, orders and counters.
    logic [31:0] slot_key[DEPTH];
    logic [3:0]  slot_verdict[DEPTH];
    logic [7:0]  use_rank[DEPTH];
    logic [7:0]  age_rank[DEPTH];
    logic [63:0] hit_count;
    logic [63:0] miss_count;

    lookup_t     pending[$];
    logic [31:0] key_pool[POOL_SIZE];
    int          errors = 0;
    longint      cycles = 0;
    int          hold_left = 0;
    bit          hold_req = 1'b0;
    bit          no_gaps = 1'b0;
    int          n_search = 0, n_hit = 0, n_insert = 0, n_flush = 0, n_odd = 0;

    row_t directed[$];

    // Clock: 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
            $display("FAIL lru_verdict_cache_unit");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    function automatic void empty_cache();
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_key[i] = '0;
            slot_verdict[i] = '0;
            use_rank[i] = 8'(i);
            age_rank[i] = 8'(i);
        end
    endfunction

    // Move one entry to the front of the recency order.
    function automatic void touch_use(input int idx);
        logic [7:0] old;
        old = use_rank[idx];
        for (int i = 0; i < DEPTH; i++)
            if (use_rank[i] < old)
                use_rank[i]++;
        use_rank[idx] = '0;
    endfunction

    // Move one entry to the front of the insertion order.
    function automatic void touch_age(input int idx);
        logic [7:0] old;
        old = age_rank[idx];
        for (int i = 0; i < DEPTH; i++)
            if (age_rank[i] < old)
                age_rank[i]++;
        age_rank[idx] = '0;
    endfunction

    // Apply one accepted item to the model; a search returns its result for the pending queue.
    function automatic lookup_t apply_item(input logic [1:0] kind, input logic [31:0] key,
                                           input logic [3:0] vin);
        lookup_t r;
        int      best;
        int      victim;
        bit      found;
        r = '0;
        best = 0;
        victim = 0;
        found = 1'b0;
        case (kind)
            KIND_SEARCH:
            begin
                n_search++;
                if (key != '0)
                    for (int i = 0; i < DEPTH; i++)
                        if (slot_key[i] == key && (!found || age_rank[i] > age_rank[best]))
                        begin
                            found = 1'b1;
                            best = i;
                        end
                if (found)
                begin
                    touch_use(best);
                    hit_count++;
                    n_hit++;
                    r.hit = 1'b1;
                    r.verdict = slot_verdict[best];
                end
                else
                    miss_count++;
                r.hits = hit_count;
                r.misses = miss_count;
            end
            KIND_INSERT:
            begin
                n_insert++;
                for (int i = 0; i < DEPTH; i++)
                    if (use_rank[i] == 8'(DEPTH - 1))
                        victim = i;
                slot_key[victim] = key;
                slot_verdict[victim] = vin;
                touch_age(victim);
                touch_use(victim);
            end
            KIND_FLUSH:
            begin
                n_flush++;
                empty_cache();
            end
            default:
                n_odd++;
        endcase
        return r;
    endfunction

    // Offer one item, honouring random gaps, and wait for it to be taken.
    task automatic send_item(input logic [1:0] kind, input logic [31:0] key,
                             input logic [3:0] vin, input bit typed, input lookup_t want);
        lookup_t r;
        while (!no_gaps && $urandom_range(99) < 27)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= kind;
        req.key <= key;
        req.verdict_in <= vin;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        r = apply_item(kind, key, vin);
        if (kind == KIND_SEARCH)
            pending.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left <= HOLD_LEN;
            hold_req <= 1'b0;
            rsp.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= no_gaps || ($urandom_range(99) >= 27);
    end

    // Compare each result item taken with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending.size() == 0)
            begin
                report("unexpected result item", 64'(rsp.hit), 64'd0);
            end
            else
            begin
                lookup_t w;
                w = pending.pop_front();
                if (rsp.hit !== w.hit)
                    report("hit", 64'(rsp.hit), 64'(w.hit));
                if (rsp.verdict_out !== w.verdict)
                    report("verdict_out", 64'(rsp.verdict_out), 64'(w.verdict));
                if (rsp.hit_total !== w.hits)
                    report("hit_total", rsp.hit_total, w.hits);
                if (rsp.miss_total !== w.misses)
                    report("miss_total", rsp.miss_total, w.misses);
            end
        end
    end

    function automatic row_t mk(input logic [1:0] kind, input logic [31:0] key,
                                input logic [3:0] vin);
        row_t t;
        t.kind = kind;
        t.key = key;
        t.verdict = vin;
        t.typed = 1'b0;
        t.want = '0;
        return t;
    endfunction

    function automatic row_t mk_typed(input logic [31:0] key, input logic hit,
                                      input logic [3:0] v, input logic [63:0] h,
                                      input logic [63:0] m);
        row_t t;
        t = mk(KIND_SEARCH, key, 4'h0);
        t.typed = 1'b1;
        t.want = '{hit: hit, verdict: v, hits: h, misses: m};
        return t;
    endfunction

    initial
    begin
        int        pick;
        logic [1:0]  kind;
        logic [31:0] key;
        logic [3:0]  vin;
        int        sent;

        req.valid = 1'b0;
        req.kind = KIND_SEARCH;
        req.key = '0;
        req.verdict_in = '0;
        rsp.ready = 1'b0;
        empty_cache();
        hit_count = '0;
        miss_count = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom() | 32'h1;

        // Directed rows: empty cache, zero key, key extremes, duplicates, odd kind, flush.
        directed.push_back(mk_typed(32'h0000_1234, 1'b0, 4'h0, 64'd0, 64'd1));
        directed.push_back(mk_typed(32'h0000_0000, 1'b0, 4'h0, 64'd0, 64'd2));
        directed.push_back(mk(KIND_INSERT, 32'hFFFF_FFFF, 4'hF));
        directed.push_back(mk_typed(32'hFFFF_FFFF, 1'b1, 4'hF, 64'd1, 64'd2));
        directed.push_back(mk(KIND_INSERT, 32'h0000_0001, 4'h0));
        directed.push_back(mk(KIND_SEARCH, 32'h0000_0001, 4'hA));
        directed.push_back(mk(KIND_INSERT, 32'hA5A5_5A5A, 4'h3));
        directed.push_back(mk(KIND_INSERT, 32'hA5A5_5A5A, 4'hC));
        directed.push_back(mk(KIND_SEARCH, 32'hA5A5_5A5A, 4'h0));
        directed.push_back(mk(KIND_INSERT, 32'h0000_0000, 4'h7));
        directed.push_back(mk(KIND_SEARCH, 32'h0000_0000, 4'h0));
        directed.push_back(mk(KIND_UNUSED, 32'hFFFF_FFFF, 4'h5));
        directed.push_back(mk(KIND_SEARCH, 32'hFFFF_FFFF, 4'h0));
        directed.push_back(mk(KIND_SEARCH, 32'h8000_0000, 4'h0));
        directed.push_back(mk(KIND_FLUSH, 32'h0000_0000, 4'h0));
        directed.push_back(mk(KIND_SEARCH, 32'hFFFF_FFFF, 4'h0));
        directed.push_back(mk(KIND_INSERT, 32'h5555_AAAA, 4'h9));
        directed.push_back(mk(KIND_SEARCH, 32'h5555_AAAA, 4'h0));

        // Hold reset, then release it.
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_item(directed[i].kind, directed[i].key, directed[i].verdict,
                      directed[i].typed, directed[i].want);

        // Random part: mostly pool keys, so hits and evictions both happen.
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 46)
                kind = KIND_SEARCH;
            else if (pick < 93)
                kind = KIND_INSERT;
            else if (pick < 96)
                kind = KIND_FLUSH;
            else
                kind = KIND_UNUSED;
            pick = $urandom_range(99);
            if (pick < 85)
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            else if (pick < 95)
                key = $urandom();
            else
                key = '0;
            vin = 4'($urandom_range(15));
            no_gaps = (sent >= 300 && sent < 400);
            if (sent == 150)
                hold_req = 1'b1;
            send_item(kind, key, vin, 1'b0, '0);
            if (kind != KIND_UNUSED)
                sent++;
        end
        req.valid <= 1'b0;
        no_gaps = 1'b0;

        // Drain, then let any trailing work settle.
        while (pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("covered %0d searches (%0d hits), %0d inserts, %0d flushes, %0d ignored kinds",
                 n_search, n_hit, n_insert, n_flush, n_odd);
        $display("%0d mismatches over %0d cycles", errors, cycles);
        if (errors == 0 && pending.size() == 0)
            $display("PASS lru_verdict_cache_unit");
        else
            $display("FAIL lru_verdict_cache_unit");
        $finish;
    end

endmodule
